### hdl/pnf_pkg.sv
// ----------------------------------------------------------------------------
// pnf_pkg
// Shared types, codes and helper functions of the 2-D Perlin fBm noise block.
// ----------------------------------------------------------------------------
`default_nettype none

package pnf_pkg;

  localparam int unsigned PermEntriesDef = 256;
  localparam int unsigned MaxOctavesDef  = 16;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_OCTAVES = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PERSIST = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LACUN   = 2'd2;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_PLAIN   = 2'd1,
    ACT_FRACTAL = 2'd2,
    ACT_RIDGED  = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_READ,
    ST_FADE,
    ST_LERP,
    ST_ACC,
    ST_AMP,
    ST_FREQ,
    ST_DIV,
    ST_FIN
  } state_e;

  // Gradient of improved Perlin noise; x and y are signed Q16.
  function automatic logic signed [19:0] grad_q16(logic [7:0] h8,
                                                  logic signed [17:0] x,
                                                  logic signed [17:0] y);
    logic [3:0]         h;
    logic signed [19:0] a;
    logic signed [19:0] b;
    h = h8[3:0];
    a = (h < 4'd8) ? 20'(x) : 20'(y);
    if (h < 4'd4) begin
      b = 20'(y);
    end else if (h == 4'd12 || h == 4'd14) begin
      b = 20'(x);
    end else begin
      b = '0;
    end
    return (h[0] ? -a : a) + (h[1] ? -b : b);
  endfunction

  // Reduction of a small index modulo the table depth by conditional subtraction.
  function automatic logic [9:0] mod_entries(logic [9:0] idx, int unsigned n);
    int unsigned r;
    r = 32'(idx);
    for (int k = 5; k >= 0; k--) begin
      if (r >= (n << k)) begin
        r = r - (n << k);
      end
    end
    return r[9:0];
  endfunction

endpackage

`default_nettype wire

### hdl/pnf_if.sv
// ----------------------------------------------------------------------------
// pnf interfaces
// Valid/ready channels for input items, results and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface pnf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] x_coord;
  logic [31:0] y_coord;
  logic [7:0]  table_index;
  logic [7:0]  table_value;

  modport source (output valid, action, x_coord, y_coord, table_index, table_value,
                  input ready);
  modport sink (input valid, action, x_coord, y_coord, table_index, table_value,
                output ready);
endinterface

interface pnf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] value;

  modport source (output valid, value, input ready);
  modport sink (input valid, value, output ready);
endinterface

interface pnf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hdl/pnf_ram.sv
// ----------------------------------------------------------------------------
// pnf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pnf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### hdl/perlin_noise_2d_fbm.sv
// ----------------------------------------------------------------------------
// perlin_noise_2d_fbm
// Improved 2-D Perlin noise with fractal and ridged octave sums.
// ----------------------------------------------------------------------------
// Table load writes one entry and gives no result. Fractal and ridged sums end
// with a restoring division and a final stage; one shared 37x18 multiplier and
// the single table read port set the octave time. One item is worked on at a time.
// Reset restores octave count 1, persistence 0.5 and lacunarity 2.0; the
// permutation table is undefined until loaded, and there is no clearing pass.
`default_nettype none

module perlin_noise_2d_fbm import pnf_pkg::*; #(
  parameter int unsigned PERM_ENTRIES = PermEntriesDef,
  parameter int unsigned MAX_OCTAVES  = MaxOctavesDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pnf_in_if.sink    items_i,
  pnf_out_if.source results_o,
  pnf_cfg_if.sink   cfg_i
);

  localparam int unsigned AW = $clog2(PERM_ENTRIES);
  localparam int unsigned OW = $clog2(MAX_OCTAVES + 1);

  state_e state_q, state_d;

  logic [2:0]         step_q;
  action_e            mode_q;
  logic [35:0]        ux_q, uy_q, acc_q;
  logic [31:0]        freq_q, amp_q;
  logic signed [55:0] sum_q;
  logic [35:0]        total_q;
  logic [OW-1:0]      oct_q, octn_q;
  logic [7:0]         xi_q, yi_q;
  logic [15:0]        xf_q, yf_q;
  logic [7:0]         pa_q, pb_q, aa_q, ab_q, ba_q, bb_q;
  logic [15:0]        p2_q, p3_q, p4_q;
  logic [16:0]        u_q, v_q;
  logic signed [19:0] x1_q, x2_q, noise_q;
  logic [55:0]        rem_q, den_q;
  logic [17:0]        quo_q;
  logic [4:0]         divk_q;
  logic               out_valid_q;
  logic [15:0]        out_value_q, out_value_d;
  logic [4:0]         octave_count_q;
  logic [15:0]        persistence_q, lacunarity_q;

  logic               accept, out_free;
  logic signed [36:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [54:0] prod;
  logic [AW-1:0]      raddr, waddr;
  logic [7:0]         rdata;
  logic [9:0]         ridx;
  logic signed [17:0] xs, xm, ys, ym;
  logic signed [19:0] g_aa, g_ba, g_ab, g_bb, diff;
  logic [15:0]        fade_t;
  logic signed [22:0] fade_f;
  logic [16:0]        fade_c;
  logic [35:0]        px;
  logic [16:0]        mag;
  logic [17:0]        shifted;
  logic [19:0]        half_noise;
  logic [5:0]         oct_lim;
  logic [OW-1:0]      oct_inc;

  assign accept       = items_i.valid && items_i.ready;
  assign items_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign out_free     = !out_valid_q || results_o.ready;
  assign oct_inc      = oct_q + OW'(1);
  assign oct_lim      = (6'(octave_count_q) > 6'(MAX_OCTAVES)) ? 6'(MAX_OCTAVES)
                                                              : 6'(octave_count_q);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octave_count_q <= 5'd1;
      persistence_q  <= 16'd8192;
      lacunarity_q   <= 16'd8192;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CFG_OCTAVES: octave_count_q <= cfg_i.data[4:0];
        CFG_PERSIST: persistence_q  <= cfg_i.data;
        CFG_LACUN:   lacunarity_q   <= cfg_i.data;
        default:     ;
      endcase
    end
  end

  // Permutation table.
  assign waddr = AW'(mod_entries({2'b00, items_i.table_index}, PERM_ENTRIES));
  assign raddr = AW'(mod_entries(ridx, PERM_ENTRIES));

  pnf_ram #(
    .Width (8),
    .Depth (PERM_ENTRIES)
  ) u_perm (
    .clk_i   (clk_i),
    .we_i    (accept && items_i.action == ACT_LOAD),
    .waddr_i (waddr),
    .wdata_i (items_i.table_value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    case (step_q)
      3'd0:    ridx = {2'b00, xi_q};
      3'd1:    ridx = 10'({2'b00, xi_q} + 10'd1);
      3'd2:    ridx = 10'(pa_q) + 10'(yi_q);
      3'd3:    ridx = 10'(pa_q) + 10'(yi_q) + 10'd1;
      3'd4:    ridx = 10'(pb_q) + 10'(yi_q);
      default: ridx = 10'(pb_q) + 10'(yi_q) + 10'd1;
    endcase
  end

  // Corner offsets in signed Q16; subtracting one is a change of the top bits.
  assign xs   = {2'b00, xf_q};
  assign xm   = {2'b11, xf_q};
  assign ys   = {2'b00, yf_q};
  assign ym   = {2'b11, yf_q};
  assign g_aa = grad_q16(aa_q, xs, ys);
  assign g_ba = grad_q16(ba_q, xm, ys);
  assign g_ab = grad_q16(ab_q, xs, ym);
  assign g_bb = grad_q16(bb_q, xm, ym);

  assign fade_t = step_q[2] ? yf_q : xf_q;

  // Shared multiplier operand selection.
  always_comb begin
    diff  = '0;
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SCALE: begin
        mul_a = {1'b0, (step_q[1] ? uy_q : ux_q)};
        mul_b = {2'b00, (step_q[0] ? freq_q[31:16] : freq_q[15:0])};
      end
      ST_FADE: begin
        case (step_q[1:0])
          2'd0:    mul_a = 37'(fade_t);
          2'd1:    mul_a = 37'(p2_q);
          2'd2:    mul_a = 37'(p3_q);
          default: mul_a = 37'(p4_q);
        endcase
        mul_b = {2'b00, fade_t};
      end
      ST_LERP: begin
        case (step_q[1:0])
          2'd0:    diff = g_ba - g_aa;
          2'd1:    diff = g_bb - g_ab;
          default: diff = x2_q - x1_q;
        endcase
        mul_a = 37'(diff);
        mul_b = {1'b0, (step_q[1] ? v_q : u_q)};
      end
      ST_ACC: begin
        mul_a = 37'(noise_q);
        mul_b = {2'b00, (step_q[0] ? amp_q[31:16] : amp_q[15:0])};
      end
      ST_AMP: begin
        mul_a = 37'(amp_q);
        mul_b = {2'b00, persistence_q};
      end
      ST_FREQ: begin
        mul_a = 37'(freq_q);
        mul_b = {2'b00, lacunarity_q};
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  // Fade combine at the fifth power: 10t^3 - 15t^4 + 6t^5, clamped to [0, 1].
  assign fade_f = 23'sd10 * 23'(p3_q) - 23'sd15 * 23'(p4_q) + 23'sd6 * 23'(prod[31:16]);
  assign fade_c = fade_f[22] ? 17'd0 : ((fade_f > 23'sd65536) ? 17'd65536 : fade_f[16:0]);

  assign px = acc_q + {prod[19:0], 16'h0000};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && items_i.action != ACT_LOAD) begin
          if (items_i.action != ACT_PLAIN && oct_lim == 6'd0) begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_SCALE;
          end
        end
      end
      ST_SCALE: if (step_q == 3'd3) state_d = ST_READ;
      ST_READ:  if (step_q == 3'd6) state_d = ST_FADE;
      ST_FADE:  if (step_q == 3'd7) state_d = ST_LERP;
      ST_LERP: begin
        if (step_q == 3'd2) state_d = (mode_q == ACT_PLAIN) ? ST_FIN : ST_ACC;
      end
      ST_ACC:  if (step_q == 3'd1) state_d = ST_AMP;
      ST_AMP:  state_d = ST_FREQ;
      ST_FREQ: state_d = (oct_inc == octn_q) ? ST_DIV : ST_SCALE;
      ST_DIV:  if (divk_q == 5'd0) state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Step counter for the multi-cycle states.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (state_d != state_q) begin
      step_q <= '0;
    end else begin
      step_q <= step_q + 3'd1;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        mode_q  <= action_e'(items_i.action);
        ux_q    <= {{4{items_i.x_coord[31]}}, items_i.x_coord};
        uy_q    <= {{4{items_i.y_coord[31]}}, items_i.y_coord};
        freq_q  <= 32'd4096;
        amp_q   <= 32'd16384;
        sum_q   <= '0;
        total_q <= '0;
        oct_q   <= '0;
        octn_q  <= OW'(oct_lim);
        quo_q   <= '0;
      end
      ST_SCALE: begin
        if (!step_q[0]) begin
          acc_q <= prod[35:0];
        end else if (!step_q[1]) begin
          xi_q <= px[35:28];
          xf_q <= px[27:12];
        end else begin
          yi_q <= px[35:28];
          yf_q <= px[27:12];
        end
      end
      ST_READ: begin
        case (step_q)
          3'd1:    pa_q <= rdata;
          3'd2:    pb_q <= rdata;
          3'd3:    aa_q <= rdata;
          3'd4:    ab_q <= rdata;
          3'd5:    ba_q <= rdata;
          3'd6:    bb_q <= rdata;
          default: ;
        endcase
      end
      ST_FADE: begin
        case (step_q[1:0])
          2'd0: p2_q <= prod[31:16];
          2'd1: p3_q <= prod[31:16];
          2'd2: p4_q <= prod[31:16];
          default: begin
            if (step_q[2]) begin
              v_q <= fade_c;
            end else begin
              u_q <= fade_c;
            end
          end
        endcase
      end
      ST_LERP: begin
        case (step_q[1:0])
          2'd0:    x1_q <= g_aa + prod[35:16];
          2'd1:    x2_q <= g_ab + prod[35:16];
          default: noise_q <= x1_q + prod[35:16];
        endcase
      end
      ST_ACC: begin
        if (!step_q[0]) begin
          sum_q <= sum_q + 56'(prod);
        end else begin
          sum_q   <= sum_q + {prod[39:0], 16'h0000};
          total_q <= total_q + 36'(amp_q);
        end
      end
      ST_AMP: begin
        amp_q <= (prod[54:46] != '0) ? 32'hFFFF_FFFF : prod[45:14];
      end
      ST_FREQ: begin
        freq_q <= (prod[54:44] != '0) ? 32'hFFFF_FFFF : prod[43:12];
        oct_q  <= oct_inc;
        rem_q  <= sum_q[55] ? 56'(-sum_q) : 56'(sum_q);
        den_q  <= 56'(total_q) << 17;
        divk_q <= 5'd17;
      end
      ST_DIV: begin
        // Restoring division, one quotient bit a cycle.
        if (rem_q >= den_q) begin
          rem_q <= rem_q - den_q;
          quo_q <= {quo_q[16:0], 1'b1};
        end else begin
          quo_q <= {quo_q[16:0], 1'b0};
        end
        den_q  <= den_q >> 1;
        divk_q <= divk_q - 5'd1;
      end
      default: ;
    endcase
  end

  // Result formatting.
  assign mag        = (quo_q > 18'd65536) ? 17'd65536 : quo_q[16:0];
  assign half_noise = 20'(noise_q >>> 1);

  always_comb begin
    shifted = '0;
    case (mode_q)
      ACT_PLAIN: begin
        if (!half_noise[19] && half_noise > 20'sd32767) begin
          out_value_d = 16'h7FFF;
        end else if (half_noise[19] && half_noise < -20'sd32768) begin
          out_value_d = 16'h8000;
        end else begin
          out_value_d = half_noise[15:0];
        end
      end
      ACT_FRACTAL: begin
        shifted     = (sum_q[55] ? 18'(18'd65536 - 18'(mag)) : 18'(18'd65536 + 18'(mag))) >> 2;
        out_value_d = shifted[15] ? 16'h7FFF : shifted[15:0];
      end
      default: begin
        shifted     = 18'(18'd65536 - 18'(mag)) >> 1;
        out_value_d = shifted[15] ? 16'h7FFF : shifted[15:0];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_FIN && out_free) begin
      out_valid_q <= 1'b1;
    end else if (results_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN && out_free) begin
      out_value_q <= out_value_d;
    end
  end

  assign results_o.valid = out_valid_q;
  assign results_o.value = out_value_q;

`ifndef ASSERT_OFF
  a_busy_after_eval : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && items_i.action != ACT_LOAD) |=> !items_i.ready)
    else $error("evaluation accepted but block still ready");

  a_fin_delivers : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && !out_valid_q) |=> out_valid_q)
    else $error("finished result not placed in output register");

  a_octave_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && state_q != ST_FIN) |-> (oct_q <= octn_q))
    else $error("octave counter passed its limit");
`endif

endmodule

`default_nettype wire
